// ----- rtl/core/akt_pkg.sv -----
// Shared types, constants and helpers for the aging key table.
package akt_pkg;

    localparam int WORD_W      = 64;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_W       = WORD_W * KEY_WORDS;
    localparam int KEY_BYTES_MAX = KEY_W / 8;
    localparam int AGE_W       = 16;
    localparam int SLOT_W      = 3;
    localparam int OP_W        = 2;
    localparam int MAX_OUT     = 8;

    localparam int ENTRIES_DEF   = 8;
    localparam int KEY_BYTES_DEF = 32;

    localparam logic [AGE_W-1:0] AGE_MAX     = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] LIMIT_RESET = AGE_W'(20);

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_SIGHT  = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] key_word0;
        logic [WORD_W-1:0] key_word1;
        logic [WORD_W-1:0] key_word2;
        logic [WORD_W-1:0] key_word3;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              matched;
        logic              live;
        logic [AGE_W-1:0]  entry_age;
        logic [WORD_W-1:0] out_word0;
        logic [WORD_W-1:0] out_word1;
        logic [WORD_W-1:0] out_word2;
        logic [WORD_W-1:0] out_word3;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic tick;
        logic clear_age;
        logic load;
    } cell_ctl_t;

    // Byte mask that keeps the first key_bytes bytes of a key.
    function automatic logic [KEY_W-1:0] key_mask(input int key_bytes);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES_MAX; b++) begin
            m[b*8 +: 8] = (b < key_bytes) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/akt_cell.sv -----
// One table entry: stored key and age, shifting to its ring neighbor.
module akt_cell
    import akt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] nbr_key,
    input  logic [AGE_W-1:0] nbr_age,
    input  logic [KEY_W-1:0] load_key,
    output logic [KEY_W-1:0] key_out,
    output logic [AGE_W-1:0] age_out
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [AGE_W-1:0] age_reg, age_next;

    always_comb begin
        key_next = key_reg;
        age_next = age_reg;
        priority if (ctl.shift) begin
            key_next = nbr_key;
            age_next = nbr_age;
        end else if (ctl.tick) begin
            // saturate at the top of the range
            if (age_reg != AGE_MAX) begin
                age_next = age_reg + AGE_W'(1);
            end
        end else begin
            if (ctl.clear_age) begin
                age_next = '0;
            end
            if (ctl.load) begin
                key_next = load_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            age_reg <= '0;
        end else begin
            key_reg <= key_next;
            age_reg <= age_next;
        end
    end

    assign key_out = key_reg;
    assign age_out = age_reg;

endmodule

// ----- rtl/core/aging_key_table_replace_oldest.sv -----
// Top level of the aging key table: ring of entry cells and its sequencer.
// The entries sit in a ring of cells that rotates one cell per cycle past a
// single head comparator, so the ring length sets the latency. A tick ages
// every entry in place. A sighting is accepted, makes one full rotation that
// finds the first matching key and the lowest-index oldest entry, and then
// updates the matched entry or else the oldest; its single result is
// presented at the end. A report rotates the ring once, one result per cycle
// for the first min(ENTRIES, 8) entries, and slows down whenever the result
// register is still held by the consumer. The table is all zero and
// limit_reg is 20 after reset; there is no clearing pass.
module aging_key_table_replace_oldest
    import akt_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_rsp,
    input  logic             cfg_we,
    input  logic [AGE_W-1:0] cfg_wdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int N_OUT = (ENTRIES < MAX_OUT) ? ENTRIES : MAX_OUT;
    localparam logic [KEY_W-1:0] KEY_MASK = key_mask(KEY_BYTES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [AGE_W-1:0] best_age_reg, best_age_next;
    logic [AGE_W-1:0] limit_reg;
    logic             m_valid_reg, m_valid_next;
    rsp_t             m_rsp_reg, m_rsp_next;

    cell_ctl_t        cell_ctl [ENTRIES];
    logic [KEY_W-1:0] cell_key [ENTRIES];
    logic [AGE_W-1:0] cell_age [ENTRIES];

    logic             accept;
    logic             out_free;
    logic             shift_en;
    logic             tick_en;
    logic             apply_en;
    logic [IDX_W-1:0] target;
    logic [KEY_W-1:0] in_key;
    logic [KEY_W-1:0] head_key;
    logic [AGE_W-1:0] head_age;

    assign in_key   = {s_req.key_word3, s_req.key_word2, s_req.key_word1, s_req.key_word0}
                      & KEY_MASK;
    assign head_key = cell_key[0];
    assign head_age = cell_age[0];
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign target   = hit_found_reg ? hit_idx_reg : best_idx_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        best_idx_next  = best_idx_reg;
        best_age_next  = best_age_reg;
        m_rsp_next     = m_rsp_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        shift_en       = 1'b0;
        tick_en        = 1'b0;
        apply_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req.op)
                        OP_TICK: begin
                            tick_en = 1'b1;
                        end
                        OP_SIGHT: begin
                            key_next       = in_key;
                            cnt_next       = '0;
                            hit_found_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        OP_REPORT: begin
                            cnt_next   = '0;
                            state_next = ST_REPORT;
                        end
                        default: begin
                            // unused op: drop the request
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                if (!hit_found_reg && (head_key == key_reg)) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cnt_reg;
                end
                // strict compare keeps the lowest index among equal ages
                if ((cnt_reg == '0) || (head_age > best_age_reg)) begin
                    best_idx_next = cnt_reg;
                    best_age_next = head_age;
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    apply_en             = 1'b1;
                    m_valid_next         = 1'b1;
                    m_rsp_next.slot      = to_slot(target);
                    m_rsp_next.matched   = hit_found_reg;
                    m_rsp_next.live      = (limit_reg != '0) && (key_reg != '0);
                    m_rsp_next.entry_age = '0;
                    m_rsp_next.out_word0 = key_reg[0*WORD_W +: WORD_W];
                    m_rsp_next.out_word1 = key_reg[1*WORD_W +: WORD_W];
                    m_rsp_next.out_word2 = key_reg[2*WORD_W +: WORD_W];
                    m_rsp_next.out_word3 = key_reg[3*WORD_W +: WORD_W];
                    m_rsp_next.last      = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    shift_en = 1'b1;
                    if ({1'b0, cnt_reg} < (IDX_W + 1)'(N_OUT)) begin
                        m_valid_next         = 1'b1;
                        m_rsp_next.slot      = to_slot(cnt_reg);
                        m_rsp_next.matched   = 1'b0;
                        m_rsp_next.live      = (head_age < limit_reg) && (head_key != '0);
                        m_rsp_next.entry_age = head_age;
                        m_rsp_next.out_word0 = head_key[0*WORD_W +: WORD_W];
                        m_rsp_next.out_word1 = head_key[1*WORD_W +: WORD_W];
                        m_rsp_next.out_word2 = head_key[2*WORD_W +: WORD_W];
                        m_rsp_next.out_word3 = head_key[3*WORD_W +: WORD_W];
                        m_rsp_next.last      = (cnt_reg == IDX_W'(N_OUT - 1));
                    end
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hit_found_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_found_reg <= hit_found_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        hit_idx_reg  <= hit_idx_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        m_rsp_reg    <= m_rsp_next;
    end

    // Cell i takes its neighbor i+1 on a shift; the head wraps to the tail.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        always_comb begin
            cell_ctl[i].shift     = shift_en;
            cell_ctl[i].tick      = tick_en;
            cell_ctl[i].clear_age = apply_en && (target == IDX_W'(i));
            cell_ctl[i].load      = apply_en && (target == IDX_W'(i)) && !hit_found_reg;
        end

        akt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl[i]),
            .nbr_key  (cell_key[(i + 1) % ENTRIES]),
            .nbr_age  (cell_age[(i + 1) % ENTRIES]),
            .load_key (key_reg),
            .key_out  (cell_key[i]),
            .age_out  (cell_age[i])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

// ----- rtl/core/akt_checker.sv -----
// Port-level checks for the aging key table, bound to the top level.
module akt_checker
    import akt_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_req,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_rsp
);

    // hold a stalled result
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_rsp))
        else $error("stalled result changed");

    a_hit_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.matched |-> m_rsp.last && (m_rsp.entry_age == '0))
        else $error("hit result must be last with age zero");

    a_partial_unmatched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.last |-> !m_rsp.matched)
        else $error("non-final result marked as hit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_req.op == OP_SIGHT) || (s_req.op == OP_REPORT))
        |=> !s_ready)
        else $error("new request taken while table is busy");

endmodule

bind aging_key_table_replace_oldest akt_checker u_akt_checker (.*);
